FILE: sv/imhq_pkg.sv
// ============================================================================
// imhq_pkg
// Shared constants and codes for the indexed min-heap priority queue.
// ============================================================================
package imhq_pkg;

    localparam int VTX_W        = 10;
    localparam int VERTEX_COUNT = 1024;
    localparam int IN_KEY_W     = 32;
    localparam int ENTRY_W      = 11;
    localparam int STATUS_W     = 3;
    localparam int OP_W         = 2;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [VTX_W-1:0]    t_vertex;
    typedef logic [IN_KEY_W-1:0] t_key;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [ENTRY_W-1:0]  t_entries;

    localparam t_op OP_INSERT   = 2'd0;
    localparam t_op OP_DECREASE = 2'd1;
    localparam t_op OP_DELETE   = 2'd2;
    localparam t_op OP_NOP      = 2'd3;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_FULL    = 3'd1;
    localparam t_status ST_EMPTY   = 3'd2;
    localparam t_status ST_ABSENT  = 3'd3;
    localparam t_status ST_PRESENT = 3'd4;

endpackage

FILE: sv/imhq_if.sv
// ============================================================================
// imhq_if
// Valid/ready channels for the operation requests and the results.
// ============================================================================
interface imhq_in_if;
    logic               valid;
    logic               ready;
    imhq_pkg::t_op      opcode;
    imhq_pkg::t_vertex  vertex;
    imhq_pkg::t_key     key;

    modport source (output valid, output opcode, output vertex, output key, input ready);
    modport sink   (input valid, input opcode, input vertex, input key, output ready);
endinterface

interface imhq_out_if;
    logic                valid;
    logic                ready;
    imhq_pkg::t_vertex   min_vertex;
    imhq_pkg::t_key      min_key;
    imhq_pkg::t_status   status;
    logic                is_empty;
    imhq_pkg::t_entries  entries;

    modport source (output valid, output min_vertex, output min_key, output status,
                    output is_empty, output entries, input ready);
    modport sink   (input valid, input min_vertex, input min_key, input status,
                    input is_empty, input entries, output ready);
endinterface

FILE: sv/indexed_min_heap_queue.sv
// ============================================================================
// indexed_min_heap_queue
// Indexed binary min-heap of vertex numbers keyed per vertex, built around
// a heap memory and a position-map memory.
// ============================================================================
// Operations run one at a time; the next transaction can be accepted in the cycle
// after the result is registered, as the single heap read port carries every heap lookup.
// The time from acceptance to a valid result grows with the number of sift-up or
// sift-down levels. Reset: synchronous and active low. After reset a clearing pass
// over all 1024 position-map entries marks every vertex absent, and no transaction
// is accepted meanwhile.
module indexed_min_heap_queue #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    imhq_in_if.sink     i_in,
    imhq_out_if.source  o_out
);
    import imhq_pkg::*;

    // Derived widths. A slot index addresses the heap memory; the count can
    // also hold CAPACITY itself. Child indices get two spare bits.
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = SLOT_W + 2;
    localparam int HEAP_W = VTX_W + KEY_BITS;
    localparam int POS_W  = SLOT_W + 1;

    // Sequencer states.
    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_POS      = 4'd2;
    localparam logic [3:0] S_DK       = 4'd3;
    localparam logic [3:0] S_UP       = 4'd4;
    localparam logic [3:0] S_UP_CMP   = 4'd5;
    localparam logic [3:0] S_DEL_TOP  = 4'd6;
    localparam logic [3:0] S_DEL_LAST = 4'd7;
    localparam logic [3:0] S_DN       = 4'd8;
    localparam logic [3:0] S_DN_C0    = 4'd9;
    localparam logic [3:0] S_DN_C1    = 4'd10;
    localparam logic [3:0] S_DN_CMP   = 4'd11;
    localparam logic [3:0] S_FIN      = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0]          r_state, n_state;
    logic [VTX_W-1:0]    r_clr, n_clr;
    logic [CNT_W-1:0]    r_count, n_count;
    t_op                 r_op, n_op;
    logic [VTX_W-1:0]    r_v, n_v;
    logic [KEY_BITS-1:0] r_k, n_k;
    // The entry being sifted travels in registers; the heap keeps a hole
    // where it will finally land.
    logic [VTX_W-1:0]    r_ev, n_ev;
    logic [KEY_BITS-1:0] r_ek, n_ek;
    logic [SLOT_W-1:0]   r_s, n_s;
    logic [VTX_W-1:0]    r_cv, n_cv;
    logic [KEY_BITS-1:0] r_ck, n_ck;
    logic [SLOT_W-1:0]   r_ci, n_ci;
    logic [VTX_W-1:0]    r_mv, n_mv;
    logic [KEY_BITS-1:0] r_mk, n_mk;
    t_status             r_st, n_st;

    // Output register.
    logic                r_ovalid;
    t_vertex             r_omv;
    t_key                r_omk;
    t_status             r_ost;
    logic                r_oempty;
    t_entries            r_oent;

    // Memory ports.
    logic                heap_we;
    logic [SLOT_W-1:0]   heap_waddr, heap_raddr;
    logic [HEAP_W-1:0]   heap_wdata, heap_rdata;
    logic                pos_we;
    logic [VTX_W-1:0]    pos_waddr, pos_raddr;
    logic [POS_W-1:0]    pos_wdata, pos_rdata;

    imhq_ram #(.WIDTH(HEAP_W), .DEPTH(CAPACITY)) u_heap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    imhq_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_COUNT)) u_pos (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // Fields of the memory words.
    logic [VTX_W-1:0]    rd_v;
    logic [KEY_BITS-1:0] rd_k;
    logic                pos_present;
    logic [SLOT_W-1:0]   pos_slot;
    logic [WIDE_W-1:0]   child0, child1, count_w;
    logic                accept;

    assign rd_v        = heap_rdata[HEAP_W-1:KEY_BITS];
    assign rd_k        = heap_rdata[KEY_BITS-1:0];
    assign pos_present = pos_rdata[POS_W-1];
    assign pos_slot    = pos_rdata[SLOT_W-1:0];
    assign child0      = WIDE_W'({r_s, 1'b1});
    assign child1      = child0 + WIDE_W'(1);
    assign count_w     = WIDE_W'(r_count);

    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_count    = r_count;
        n_op       = r_op;
        n_v        = r_v;
        n_k        = r_k;
        n_ev       = r_ev;
        n_ek       = r_ek;
        n_s        = r_s;
        n_cv       = r_cv;
        n_ck       = r_ck;
        n_ci       = r_ci;
        n_mv       = r_mv;
        n_mk       = r_mk;
        n_st       = r_st;
        heap_we    = 1'b0;
        heap_waddr = r_s;
        heap_wdata = {r_ev, r_ek};
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = r_ev;
        pos_wdata  = {1'b1, r_s};
        pos_raddr  = i_in.vertex;

        unique case (r_state)
            S_CLR: begin
                // Sweep the position map so every vertex reads as absent.
                pos_we    = 1'b1;
                pos_waddr = r_clr;
                pos_wdata = '0;
                n_clr     = r_clr + VTX_W'(1);
                if (r_clr == {VTX_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op = i_in.opcode;
                    n_v  = i_in.vertex;
                    n_k  = KEY_BITS'(i_in.key);
                    n_mv = '0;
                    n_mk = '0;
                    n_st = ST_OK;
                    if (i_in.opcode == OP_DELETE) begin
                        if (r_count == '0) begin
                            n_st    = ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_DEL_TOP;
                        end
                    end else if (i_in.opcode == OP_NOP) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_POS;
                    end
                end
            end
            S_POS: begin
                if (r_op == OP_INSERT) begin
                    if (pos_present) begin
                        n_st    = ST_PRESENT;
                        n_state = S_DONE;
                    end else if (r_count >= CNT_W'(CAPACITY)) begin
                        n_st    = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_s     = SLOT_W'(r_count);
                        n_ev    = r_v;
                        n_ek    = r_k;
                        n_count = r_count + CNT_W'(1);
                        n_state = S_UP;
                    end
                end else begin
                    if (!pos_present) begin
                        n_st    = ST_ABSENT;
                        n_state = S_DONE;
                    end else begin
                        n_s        = pos_slot;
                        heap_raddr = pos_slot;
                        n_state    = S_DK;
                    end
                end
            end
            S_DK: begin
                // Only a strictly lower key moves anything.
                if (r_k < rd_k) begin
                    n_ev    = r_v;
                    n_ek    = r_k;
                    n_state = S_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UP: begin
                if (r_s == '0) begin
                    n_state = S_FIN;
                end else begin
                    heap_raddr = (r_s - SLOT_W'(1)) >> 1;
                    n_state    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (rd_k > r_ek) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_v;
                    n_s        = (r_s - SLOT_W'(1)) >> 1;
                    n_state    = S_UP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DEL_TOP: begin
                n_mv      = rd_v;
                n_mk      = rd_k;
                pos_we    = 1'b1;
                pos_waddr = rd_v;
                pos_wdata = '0;
                n_count   = r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    heap_raddr = SLOT_W'(r_count - CNT_W'(1));
                    n_state    = S_DEL_LAST;
                end
            end
            S_DEL_LAST: begin
                n_ev    = rd_v;
                n_ek    = rd_k;
                n_s     = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (child0 >= count_w) begin
                    n_state = S_FIN;
                end else begin
                    heap_raddr = SLOT_W'(child0);
                    n_state    = S_DN_C0;
                end
            end
            S_DN_C0: begin
                n_cv = rd_v;
                n_ck = rd_k;
                n_ci = SLOT_W'(child0);
                if (child1 < count_w) begin
                    heap_raddr = SLOT_W'(child1);
                    n_state    = S_DN_C1;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_C1: begin
                // The right child wins only when strictly smaller.
                if (r_ck > rd_k) begin
                    n_cv = rd_v;
                    n_ck = rd_k;
                    n_ci = SLOT_W'(child1);
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (r_ek > r_ck) begin
                    heap_we    = 1'b1;
                    heap_wdata = {r_cv, r_ck};
                    pos_we     = 1'b1;
                    pos_waddr  = r_cv;
                    n_s        = r_ci;
                    n_state    = S_DN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Drop the sifted entry into the hole and record its slot.
                heap_we = 1'b1;
                pos_we  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            if (r_state == S_DONE && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_v  <= n_v;
        r_k  <= n_k;
        r_ev <= n_ev;
        r_ek <= n_ek;
        r_s  <= n_s;
        r_cv <= n_cv;
        r_ck <= n_ck;
        r_ci <= n_ci;
        r_mv <= n_mv;
        r_mk <= n_mk;
        r_st <= n_st;
        if (r_state == S_DONE && (!r_ovalid || o_out.ready)) begin
            r_omv    <= r_mv;
            r_omk    <= IN_KEY_W'(r_mk);
            r_ost    <= r_st;
            r_oempty <= (r_count == '0);
            r_oent   <= ENTRY_W'(r_count);
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.min_vertex = r_omv;
    assign o_out.min_key    = r_omk;
    assign o_out.status     = r_ost;
    assign o_out.is_empty   = r_oempty;
    assign o_out.entries    = r_oent;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Every heap write lands inside the occupied region.
    a_heap_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        heap_we |-> (CNT_W'(heap_waddr) < r_count))
        else $error("heap write beyond entry count");

    // An accepted transaction always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted transaction not started");

    // A held result is not overwritten before it is taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> (r_ovalid && $stable(r_ost) && $stable(r_oent)))
        else $error("pending result changed");

endmodule

FILE: sv/imhq_ram.sv
// ============================================================================
// imhq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
